[hw/rtl/ffpa_pkg.sv]
`default_nettype none

package ffpa_pkg;

	// Map word: pages checked per memory read
	localparam int WORD_BITS = 32;

	// Default geometry
	localparam int NUM_PAGES_DEF  = 4096;
	localparam int PAGE_BYTES_DEF = 4096;

	// Request codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// Outcome of checking one map word
	typedef struct packed {
		logic       hit;        // a long enough run ends in this word
		logic       carry_hit;  // that run is the carried run extended here
		logic [4:0] hit_bit;    // first bit of a run held wholly in this word
		logic       all_free;   // no used page in this word
		logic [5:0] top_free;   // free pages at the top end of the word
	} ffpa_scan_t;

endpackage

`default_nettype wire

[hw/rtl/ffpa_word_scan.sv]
`default_nettype none

// Checks one 32-page map word against the run carried in from lower words.
module ffpa_word_scan import ffpa_pkg::*; #(
	parameter int CW = 13
) (
	input  wire logic [WORD_BITS-1:0] used_word,
	input  wire logic [CW-1:0]        run_in,
	input  wire logic [CW-1:0]        need,
	output ffpa_scan_t                res
);

	localparam int SW = ((CW > 6) ? CW : 6) + 1;
	localparam logic [WORD_BITS-1:0] ONES = '1;

	logic [WORD_BITS-1:0] free_w;
	logic [5:0]           low_free;
	logic [5:0]           high_free;
	logic [SW-1:0]        need_ext;
	logic [SW-1:0]        reach;
	logic                 need_small;
	logic [5:0]           need6;
	logic [WORD_BITS-1:0] lowm;
	logic [WORD_BITS-1:0] fit;
	logic [4:0]           first_fit;
	logic                 fit_seen;

	assign free_w = ~used_word;

	// Free run length at bit 0 and at bit 31: position of the nearest used page
	always_comb begin
		low_free  = 6'd32;
		high_free = 6'd32;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!free_w[i]) begin
				low_free = 6'(i);
			end
		end
		for (int i = 0; i < WORD_BITS; i++) begin
			if (!free_w[i]) begin
				high_free = 6'(WORD_BITS - 1 - i);
			end
		end
	end

	// Carried run extended by the low free bits
	assign need_ext   = SW'(need);
	assign reach      = SW'(run_in) + SW'(low_free);
	assign need_small = (need_ext <= SW'(WORD_BITS));
	assign need6      = need_ext[5:0];
	assign lowm       = ONES >> (6'd32 - need6);

	// Start positions of a run of need pages inside the word
	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			fit[i] = need_small & (&(((free_w >> i) & lowm) | ~lowm));
		end
	end

	always_comb begin
		first_fit = 5'd0;
		fit_seen  = 1'b0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (!fit_seen && fit[i]) begin
				first_fit = 5'(i);
				fit_seen  = 1'b1;
			end
		end
	end

	always_comb begin
		res.carry_hit = (reach >= need_ext);
		res.hit       = res.carry_hit | fit_seen;
		res.hit_bit   = first_fit;
		res.all_free  = &free_w;
		res.top_free  = high_free;
	end

endmodule

`default_nettype wire

[hw/rtl/first_fit_page_bitmap_allocator_top.sv]
`default_nettype none

// First-fit page allocator over a one-bit-per-page occupancy map kept in a
// 32-bit-wide RAM. A request is taken when start is high and busy is low;
// its single result appears on ok and run_offset for one cycle with done,
// and the receiver must take it then. Each request first turns the byte
// size and the offset into pages with one shared reciprocal multiply and a
// single correction step per value: estimate, remainder, correction. An
// allocate then reads the map one word per cycle from page 0 until a run
// fits, checking each word as its read data returns, and marks the run
// with a read-modify-write of each word covered; failure is reported
// after the last word. A free clears its pages by the same read-modify-write.
// A new request can be taken in the cycle that done is high. After reset
// the map is cleared one word per cycle with busy held high. PAGE_BYTES
// need not be a power of two.
module first_fit_page_bitmap_allocator_top import ffpa_pkg::*; #(
	parameter int NUM_PAGES  = NUM_PAGES_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic        func,
	input  wire logic [31:0] size_bytes,
	input  wire logic [23:0] free_offset,
	output      logic        done,
	output      logic        ok,
	output      logic [23:0] run_offset
);

	localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WAW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int PIW       = WAW + 5;
	localparam int CW        = $clog2(NUM_PAGES + 1);
	localparam int RW        = $clog2(PAGE_BYTES) + 1;
	localparam int PRODW     = (PIW + 17 > 24) ? PIW + 17 : 24;
	localparam int TAIL      = NUM_PAGES - (NUM_WORDS - 1) * WORD_BITS;
	localparam int RECW      = 25;
	localparam logic [WAW-1:0]       LAST_WORD = WAW'(NUM_WORDS - 1);
	localparam logic [WORD_BITS-1:0] ONES      = '1;
	localparam logic [WORD_BITS-1:0] PAD_MASK  = ~(ONES >> (WORD_BITS - TAIL));
	// floor(2^32 / PAGE_BYTES); quotient estimate is exact or one low
	localparam logic [RECW-1:0]      RECIP     = RECW'((64'd1 << 32) / 64'(PAGE_BYTES));

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_DIV,
		ST_PREP,
		ST_SCAN,
		ST_RMW_RD,
		ST_RMW_WR
	} state_t;

	state_t         state_q;
	logic [4:0]     step_q;
	logic           func_q;
	logic [31:0]    sz_dvd_q;
	logic [RW-1:0]  sz_rem_q;
	logic [31:0]    off_dvd_q;
	logic [RECW-1:0] quo_q;
	logic [31:0]    rem_q;
	logic [CW-1:0]  need_q;
	logic [CW-1:0]  run_q;
	logic [PIW-1:0] start_q;
	logic [PIW-1:0] first_q;
	logic [PIW-1:0] last_q;
	logic           set_q;
	logic [WAW-1:0] clr_addr_q;
	logic [WAW-1:0] scan_addr_q;
	logic           scan_stop_q;
	logic [WAW-1:0] cur_word_q;
	logic           rvalid_s1;
	logic [WAW-1:0] rword_s1;
	logic [WORD_BITS-1:0] rdata_s1;
	logic           done_q;
	logic           ok_q;
	logic [23:0]    offset_q;

	logic [WORD_BITS-1:0] map_mem [NUM_WORDS];

	// Shared divide by PAGE_BYTES: size in steps 0-2, offset in steps 3-5
	logic [31:0]     div_x;
	logic [56:0]     recip_prod;
	logic [31:0]     qd_prod;
	logic            rem_ge;
	logic [RECW-1:0] quo_fix;
	logic [31:0]     rem_fix;

	assign div_x      = (step_q < 5'd3) ? sz_dvd_q : off_dvd_q;
	assign recip_prod = 57'(div_x) * 57'(RECIP);
	assign qd_prod    = 32'(quo_q) * 32'(PAGE_BYTES);
	assign rem_ge     = (rem_q >= 32'(PAGE_BYTES));
	assign quo_fix    = quo_q + RECW'(rem_ge);
	assign rem_fix    = rem_ge ? rem_q - 32'(PAGE_BYTES) : rem_q;

	// Request decode after the divide
	logic [31:0] pages;
	logic [32:0] end_page;
	logic [32:0] end_clamp;

	assign pages     = sz_dvd_q + {31'd0, |sz_rem_q};
	assign end_page  = {1'b0, off_dvd_q} + {1'b0, pages};
	assign end_clamp = (end_page > 33'(NUM_PAGES)) ? 33'(NUM_PAGES) : end_page;

	// Word check
	logic                 scan_issue;
	logic [WORD_BITS-1:0] used_word;
	ffpa_scan_t           scan_res;
	logic [PIW-1:0]       word_base;
	logic [PIW-1:0]       hit_start;

	assign scan_issue = (state_q == ST_SCAN) && !scan_stop_q;
	assign used_word  = rdata_s1 | ((rword_s1 == LAST_WORD) ? PAD_MASK : '0);
	assign word_base  = {rword_s1, 5'd0};
	assign hit_start  = scan_res.carry_hit ? start_q : word_base + PIW'(scan_res.hit_bit);

	ffpa_word_scan #(
		.CW(CW)
	) u_word_scan (
		.used_word(used_word),
		.run_in   (run_q),
		.need     (need_q),
		.res      (scan_res)
	);

	// Range mask for read-modify-write
	logic [4:0]           lo_bit;
	logic [4:0]           hi_bit;
	logic [WORD_BITS-1:0] rmw_mask;
	logic [WORD_BITS-1:0] rmw_data;

	assign lo_bit   = (cur_word_q == first_q[PIW-1:5]) ? first_q[4:0] : 5'd0;
	assign hi_bit   = (cur_word_q == last_q[PIW-1:5]) ? last_q[4:0] : 5'd31;
	assign rmw_mask = (ONES << lo_bit) & (ONES >> (5'd31 - hi_bit));
	assign rmw_data = set_q ? (rdata_s1 | rmw_mask) : (rdata_s1 & ~rmw_mask);

	// Byte offset of an allocated run
	logic [PRODW-1:0] offset_prod;

	assign offset_prod = PRODW'(first_q) * PRODW'(PAGE_BYTES);

	// Map memory ports
	logic           mem_we;
	logic [WAW-1:0] mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic           mem_re;
	logic [WAW-1:0] mem_raddr;

	assign mem_we    = (state_q == ST_CLR) || (state_q == ST_RMW_WR);
	assign mem_waddr = (state_q == ST_CLR) ? clr_addr_q : cur_word_q;
	assign mem_wdata = (state_q == ST_CLR) ? '0 : rmw_data;
	assign mem_re    = scan_issue || (state_q == ST_RMW_RD);
	assign mem_raddr = (state_q == ST_SCAN) ? scan_addr_q : cur_word_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_s1 <= map_mem[mem_raddr];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			step_q      <= 5'd0;
			func_q      <= FUNC_ALLOC;
			sz_dvd_q    <= '0;
			sz_rem_q    <= '0;
			off_dvd_q   <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			need_q      <= '0;
			run_q       <= '0;
			start_q     <= '0;
			first_q     <= '0;
			last_q      <= '0;
			set_q       <= 1'b0;
			clr_addr_q  <= '0;
			scan_addr_q <= '0;
			scan_stop_q <= 1'b0;
			cur_word_q  <= '0;
			rvalid_s1   <= 1'b0;
			rword_s1    <= '0;
			done_q      <= 1'b0;
			ok_q        <= 1'b0;
			offset_q    <= '0;
		end else begin
			done_q    <= 1'b0;
			rvalid_s1 <= scan_issue;
			if (scan_issue) begin
				rword_s1 <= scan_addr_q;
			end
			case (state_q)
				ST_CLR: begin
					if (clr_addr_q == LAST_WORD) begin
						state_q <= ST_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + WAW'(1);
					end
				end
				ST_IDLE: begin
					if (start) begin
						func_q    <= func;
						sz_dvd_q  <= size_bytes;
						sz_rem_q  <= '0;
						off_dvd_q <= {8'd0, free_offset};
						step_q    <= 5'd0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 5'd1;
					case (step_q)
						// quotient estimate, then remainder, then correction
						5'd0, 5'd3: begin
							quo_q <= recip_prod[56:32];
						end
						5'd1, 5'd4: begin
							rem_q <= div_x - qd_prod;
						end
						5'd2: begin
							sz_dvd_q <= 32'(quo_fix);
							sz_rem_q <= RW'(rem_fix);
						end
						default: begin
							off_dvd_q <= 32'(quo_fix);
							state_q   <= ST_PREP;
						end
					endcase
				end
				ST_PREP: begin
					if (func_q == FUNC_ALLOC) begin
						if ((pages == 32'd0) || (pages > 32'(NUM_PAGES))) begin
							done_q   <= 1'b1;
							ok_q     <= 1'b0;
							offset_q <= '0;
							state_q  <= ST_IDLE;
						end else begin
							need_q      <= pages[CW-1:0];
							run_q       <= '0;
							start_q     <= '0;
							scan_addr_q <= '0;
							scan_stop_q <= 1'b0;
							set_q       <= 1'b1;
							state_q     <= ST_SCAN;
						end
					end else begin
						if ((pages == 32'd0) || (off_dvd_q >= 32'(NUM_PAGES))) begin
							done_q   <= 1'b1;
							ok_q     <= 1'b1;
							offset_q <= '0;
							state_q  <= ST_IDLE;
						end else begin
							first_q    <= off_dvd_q[PIW-1:0];
							last_q     <= PIW'(end_clamp - 33'd1);
							cur_word_q <= off_dvd_q[PIW-1:5];
							set_q      <= 1'b0;
							state_q    <= ST_RMW_RD;
						end
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						if (scan_addr_q == LAST_WORD) begin
							scan_stop_q <= 1'b1;
						end else begin
							scan_addr_q <= scan_addr_q + WAW'(1);
						end
					end
					if (rvalid_s1) begin
						if (scan_res.hit) begin
							first_q    <= hit_start;
							last_q     <= hit_start + PIW'(need_q) - PIW'(1);
							cur_word_q <= hit_start[PIW-1:5];
							state_q    <= ST_RMW_RD;
						end else if (rword_s1 == LAST_WORD) begin
							done_q   <= 1'b1;
							ok_q     <= 1'b0;
							offset_q <= '0;
							state_q  <= ST_IDLE;
						end else if (scan_res.all_free) begin
							run_q <= run_q + CW'(WORD_BITS);
						end else begin
							run_q   <= CW'(scan_res.top_free);
							start_q <= word_base + PIW'(6'd32 - scan_res.top_free);
						end
					end
				end
				ST_RMW_RD: begin
					state_q <= ST_RMW_WR;
				end
				ST_RMW_WR: begin
					if (cur_word_q == last_q[PIW-1:5]) begin
						done_q   <= 1'b1;
						ok_q     <= 1'b1;
						offset_q <= set_q ? offset_prod[23:0] : 24'd0;
						state_q  <= ST_IDLE;
					end else begin
						cur_word_q <= cur_word_q + WAW'(1);
						state_q    <= ST_RMW_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign ok         = ok_q;
	assign run_offset = offset_q;

	// Checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in progress");

	a_free_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (func_q == FUNC_FREE)) |-> (ok && (run_offset == 24'd0)))
		else $error("free returned failure or nonzero offset");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (run_offset == 24'd0))
		else $error("failed allocate returned nonzero offset");

endmodule

`default_nettype wire
